// File: rtl/assert_macros.svh
// Assertion macros used by the tracker top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/frt_pkg.sv
// Types, constants and codes of the fragment reassembly tracker
package frt_pkg;
    localparam int NumSlots = 16;
    localparam int MaxFrags = 64;
    localparam int SlotW = $clog2(NumSlots);
    localparam int IdxW = $clog2(MaxFrags);
    localparam int TotW = IdxW + 1;
    localparam logic [15:0] HdrBytes = 16'd32;
    localparam logic [15:0] MtuReset = 16'd1472;

    typedef enum logic [1:0] {
        REQ_FRAG  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_PURGE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_STORED   = 4'd0,
        ST_COMPLETE = 4'd1,
        ST_SHORT    = 4'd2,
        ST_BAD_IDX  = 4'd3,
        ST_NONLAST  = 4'd4,
        ST_MISMATCH = 4'd5,
        ST_DUP      = 4'd6,
        ST_FULL     = 4'd7,
        ST_TOO_MANY = 4'd8,
        ST_DONE     = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL_OFS,
        S_MUL_LEN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] msg_id_high;
        logic [63:0] msg_id_low;
        logic [63:0] frag_index;
        logic [63:0] frag_total;
        logic [15:0] packet_bytes;
        logic [31:0] age_limit;
    } t_req_word;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic [21:0] write_offset;
        logic [15:0] write_bytes;
        logic [22:0] message_bytes;
        logic [4:0]  purged_count;
    } t_rsp_word;
endpackage

// File: rtl/frt_mul.sv
// Shared registered multiplier for offsets and message length
module frt_mul (
    input  logic        i_clk,
    input  logic [6:0]  i_a,
    input  logic [15:0] i_b,
    output logic [22:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= 23'(i_a) * 23'(i_b);
    end
endmodule

// File: rtl/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker
// Fragment and purge words pass a slot scan, offset multiply, length multiply and emit
// before the result strobe; tick and unknown words finish in the scan state.
// Busy from accept until the result strobe; the next word is taken at the edge ending
// the strobe, so only one word is in flight at a time.
// Results strobe for one cycle; the receiver cannot stall.
// Synchronous active-low reset frees all slots, zeroes time, restores mtu 1472.
`include "assert_macros.svh"
module fragment_reassembly_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  frt_pkg::t_req_word    i_req,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data,
    output logic                  o_rsp_valid,
    output frt_pkg::t_rsp_word    o_rsp
);
    localparam int SW = frt_pkg::SlotW;
    localparam int IW = frt_pkg::IdxW;
    localparam int TW = frt_pkg::TotW;
    localparam int NS = frt_pkg::NumSlots;

    frt_pkg::t_state r_state, n_state;
    frt_pkg::t_req_word r_req;
    logic [15:0] r_mtu;
    logic [31:0] r_time;
    logic [NS-1:0] r_use;
    logic [63:0] r_idh [NS];
    logic [63:0] r_idl [NS];
    logic [TW-1:0] r_tot [NS];
    logic [63:0] r_map [NS];
    logic [15:0] r_tail [NS];
    logic [31:0] r_touch [NS];

    logic [SW:0] r_cnt;
    logic r_hit, r_free_ok;
    logic [SW-1:0] r_hit_slot, r_free_slot;
    logic [4:0] r_purged;
    frt_pkg::t_rsp_word r_rsp;
    logic r_valid;
    logic n_valid;
    logic [15:0] r_pkt;
    logic [22:0] mul_p;
    logic [6:0] mul_a;
    logic [15:0] payload;
    logic [SW-1:0] cur;
    logic id_eq;

    assign cur = r_cnt[SW-1:0];
    assign payload = (r_mtu > frt_pkg::HdrBytes) ? r_mtu - frt_pkg::HdrBytes : 16'd0;
    assign id_eq = r_use[cur] && r_idh[cur] == r_req.msg_id_high
                   && r_idl[cur] == r_req.msg_id_low;
    assign mul_a = (r_state == frt_pkg::S_MUL_OFS) ? 7'(r_req.frag_index[IW-1:0])
                                                 : 7'(r_req.frag_total[TW-1:0] - 1'b1);

    frt_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(payload), .o_p(mul_p));

    assign busy = r_state != frt_pkg::S_IDLE;
    assign o_rsp_valid = r_valid;
    assign o_rsp = r_rsp;
    assign n_valid = (r_state == frt_pkg::S_EMIT)
                     || (r_state == frt_pkg::S_SCAN
                         && (r_req.req_type == frt_pkg::REQ_TICK
                             || r_req.req_type == frt_pkg::REQ_NONE));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frt_pkg::S_IDLE:    if (start) n_state = frt_pkg::S_SCAN;
            frt_pkg::S_SCAN: begin
                if (r_req.req_type == frt_pkg::REQ_TICK || r_req.req_type == frt_pkg::REQ_NONE)
                    n_state = frt_pkg::S_IDLE;
                else if (r_cnt == (SW+1)'(NS)) n_state = frt_pkg::S_MUL_OFS;
            end
            frt_pkg::S_MUL_OFS: n_state = frt_pkg::S_MUL_LEN;
            frt_pkg::S_MUL_LEN: n_state = frt_pkg::S_EMIT;
            frt_pkg::S_EMIT:    n_state = frt_pkg::S_IDLE;
            default:            n_state = frt_pkg::S_IDLE;
        endcase
    end

    logic idle_more;
    assign idle_more = (r_time - r_touch[cur]) > r_req.age_limit;

    // final decision, done in S_EMIT with registered products
    logic [22:0] r_ofs;
    logic [SW-1:0] s;
    logic [63:0] newmap, bit_m, fullm;
    logic last, dup;
    logic [15:0] bytes;
    assign s = r_hit ? r_hit_slot : r_free_slot;
    assign last = r_req.frag_index == r_req.frag_total - 64'd1;
    assign bit_m = 64'd1 << r_req.frag_index[IW-1:0];
    assign dup = r_hit && (r_map[s] & bit_m) != 64'd0;
    assign newmap = (r_hit ? r_map[s] : 64'd0) | bit_m;
    assign fullm = (r_req.frag_total >= 64'd64) ? '1
                   : ((64'd1 << r_req.frag_total[5:0]) - 64'd1);
    assign bytes = r_pkt - frt_pkg::HdrBytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frt_pkg::S_IDLE;
            r_use <= '0;
            r_time <= '0;
            r_mtu <= frt_pkg::MtuReset;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) r_mtu <= i_cfg_data;
            unique case (r_state)
                frt_pkg::S_IDLE: if (start) begin
                    r_req <= i_req;
                    r_cnt <= '0;
                    r_hit <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_purged <= '0;
                    r_pkt <= (i_req.packet_bytes > r_mtu) ? r_mtu : i_req.packet_bytes;
                end
                frt_pkg::S_SCAN: begin
                    if (r_req.req_type == frt_pkg::REQ_TICK
                        || r_req.req_type == frt_pkg::REQ_NONE) begin
                        if (r_req.req_type == frt_pkg::REQ_TICK) r_time <= r_time + 32'd1;
                        r_rsp <= '{status: frt_pkg::ST_DONE, default: '0};
                    end else if (r_cnt != (SW+1)'(NS)) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_req.req_type == frt_pkg::REQ_PURGE) begin
                            if (r_use[cur] && idle_more) begin
                                r_use[cur] <= 1'b0;
                                r_purged <= r_purged + 5'd1;
                            end
                        end else begin
                            if (id_eq && !r_hit) begin
                                r_hit <= 1'b1;
                                r_hit_slot <= cur;
                            end
                            if (!r_use[cur] && !r_free_ok) begin
                                r_free_ok <= 1'b1;
                                r_free_slot <= cur;
                            end
                        end
                    end
                end
                frt_pkg::S_MUL_OFS: ;
                frt_pkg::S_MUL_LEN: r_ofs <= mul_p;
                frt_pkg::S_EMIT: begin
                    r_rsp <= '0;
                    if (r_req.req_type == frt_pkg::REQ_PURGE) begin
                        r_rsp.status <= frt_pkg::ST_DONE;
                        r_rsp.purged_count <= r_purged;
                    end else if (r_pkt <= frt_pkg::HdrBytes) begin
                        r_rsp.status <= frt_pkg::ST_SHORT;
                    end else if (r_req.frag_index >= r_req.frag_total) begin
                        r_rsp.status <= frt_pkg::ST_BAD_IDX;
                    end else if (!last && r_pkt != r_mtu) begin
                        r_rsp.status <= frt_pkg::ST_NONLAST;
                    end else if (r_hit && 64'(r_tot[s]) != r_req.frag_total) begin
                        r_rsp.status <= frt_pkg::ST_MISMATCH;
                        r_rsp.slot <= 4'(s);
                    end else if (!r_hit && r_req.frag_total > 64'(frt_pkg::MaxFrags)) begin
                        r_rsp.status <= frt_pkg::ST_TOO_MANY;
                    end else if (!r_hit && !r_free_ok) begin
                        r_rsp.status <= frt_pkg::ST_FULL;
                    end else begin
                        r_rsp.slot <= 4'(s);
                        r_touch[s] <= r_time;
                        if (!r_hit) begin
                            r_idh[s] <= r_req.msg_id_high;
                            r_idl[s] <= r_req.msg_id_low;
                            r_tot[s] <= r_req.frag_total[TW-1:0];
                        end
                        if (dup) begin
                            r_rsp.status <= frt_pkg::ST_DUP;
                        end else begin
                            r_map[s] <= newmap;
                            r_rsp.write_offset <= r_ofs[21:0];
                            r_rsp.write_bytes <= bytes;
                            if (newmap == fullm) begin
                                r_rsp.status <= frt_pkg::ST_COMPLETE;
                                r_use[s] <= 1'b0;
                                r_rsp.message_bytes <= mul_p
                                    + 23'(last ? bytes : (r_hit ? r_tail[s] : 16'd0));
                            end else begin
                                r_rsp.status <= frt_pkg::ST_STORED;
                                r_use[s] <= 1'b1;
                                if (last) r_tail[s] <= bytes;
                                else if (!r_hit) r_tail[s] <= 16'd0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_valid_busy_end, i_clk, i_rst_n, r_valid, r_state == frt_pkg::S_IDLE)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_cnt_range, i_clk, i_rst_n, busy, r_cnt <= (SW+1)'(NS))
endmodule
